@@ rtl/ptz_position_preset_engine_defines.svh @@
// Assertion macros for the PTZ position and preset engine.
`ifndef PTZ_POSITION_PRESET_ENGINE_DEFINES_SVH
`define PTZ_POSITION_PRESET_ENGINE_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next clock edge.
`define PTZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Assert that a condition holds at every clock edge outside reset.
`define PTZ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ rtl/ptz_pkg.sv @@
// Package of types, constants and status codes for the PTZ preset engine.
`default_nettype none
package ptz_pkg;

  localparam int unsigned PresetSlotsDefault = 16;

  localparam int unsigned InWidth  = 64;
  localparam int unsigned OutWidth = 40;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BUSY        = 4'd1,
    ST_AXIS        = 4'd2,
    ST_CONSTRAINT  = 4'd3,
    ST_INVALID     = 4'd4,
    ST_FULL        = 4'd5,
    ST_NOTFOUND    = 4'd6,
    ST_REJECTED    = 4'd7,
    ST_UNSUPPORTED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    REQ_SET    = 3'd0,
    REQ_REL    = 3'd1,
    REQ_GOTO   = 3'd2,
    REQ_SAVE   = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_BAD5   = 3'd5,
    REQ_BAD6   = 3'd6,
    REQ_BAD7   = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    CFG_FEATURE    = 3'd0,
    CFG_PAN_LO     = 3'd1,
    CFG_PAN_HI     = 3'd2,
    CFG_TILT_LO    = 3'd3,
    CFG_TILT_HI    = 3'd4,
    CFG_ZOOM_HI    = 3'd5,
    CFG_PRESET_LIM = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_LOAD_RD,
    S_LOAD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
    logic [7:0]         zoom;
  } entry_t;

  function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
                                                 logic signed [15:0] lo,
                                                 logic signed [15:0] hi);
    logic signed [15:0] r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ptz_position_preset_engine.sv @@
// Top level of the PTZ position and preset engine.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    s_axis_tdata: command fields
//  m_axis    out  m_axis_tvalid/tready    m_axis_tdata: status and position
//  cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
//  Set, relative move and any answer given without a table walk pass S_IDLE, S_DECIDE
//  and S_OUT. Goto and remove add S_FIND_RD and S_FIND_CHK per entry searched (goto
//  adds S_LOAD on a hit); remove adds S_SHIFT_RD and S_SHIFT_WR per entry moved up.
//  Save adds an ID allocation walk of S_ALLOC_RD and S_ALLOC_CHK per entry read, up
//  to count+1 reads per try, at most preset_limit-1 tries. Reset zeroes pan, tilt and
//  counters, sets zoom and next ID to 1 and leaves the table unwritten. A new
//  request is taken while the result waits; the next result waits for it.
`default_nettype none
module ptz_position_preset_engine
  import ptz_pkg::*;
#(
  parameter int unsigned PRESET_SLOTS = PresetSlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // req_type[2:0], pan_given, pan_value[15:0], tilt_given, tilt_value[15:0],
  // zoom_given, zoom_value[7:0], preset_number[7:0], preset_number_given,
  // device_ready, device_accepts, zero fill
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status[3:0], pan_now[8:0], tilt_now[8:0], zoom_now[6:0], preset_used[7:0],
  // zero fill
  output logic [OutWidth-1:0]      m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [8:0]          cfg_data_i
);

  localparam int unsigned IdxW = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(PRESET_SLOTS + 1);

  `include "ptz_position_preset_engine_defines.svh"

  // configuration
  logic [3:0] feat_q;
  logic signed [8:0] plo_q, phi_q, tlo_q, thi_q;
  logic [6:0] zhi_q;
  logic [4:0] plim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_q <= 4'd15;
      plo_q  <= -9'sd180;
      phi_q  <= 9'sd180;
      tlo_q  <= -9'sd180;
      thi_q  <= 9'sd180;
      zhi_q  <= 7'd100;
      plim_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FEATURE:    feat_q <= cfg_data_i[3:0];
        CFG_PAN_LO:     plo_q  <= cfg_data_i;
        CFG_PAN_HI:     phi_q  <= cfg_data_i;
        CFG_TILT_LO:    tlo_q  <= cfg_data_i;
        CFG_TILT_HI:    thi_q  <= cfg_data_i;
        CFG_ZOOM_HI:    zhi_q  <= cfg_data_i[6:0];
        CFG_PRESET_LIM: plim_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // table memory
  entry_t mem [PRESET_SLOTS];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // state
  state_e state_q, state_d;
  logic signed [15:0] pan_q, pan_d, tilt_q, tilt_d;
  logic [7:0] zoom_q, zoom_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0] next_q, next_d;
  logic [InWidth-1:0] cmd_q, cmd_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic hit;
  logic [7:0] key_q, key_d;
  logic [4:0] step_q, step_d;
  logic [3:0] st_q, st_d;
  logic [7:0] used_q, used_d;
  logic out_v_q, out_v_d;
  logic [OutWidth-1:0] out_q, out_d;

  // command fields
  logic [2:0] c_req;
  logic c_pg, c_tg, c_zg, c_png, c_rdy, c_acc;
  logic signed [15:0] c_pv, c_tv;
  logic signed [7:0] c_zv;
  logic [7:0] c_num;
  assign c_req = cmd_q[2:0];
  assign c_pg  = cmd_q[3];
  assign c_pv  = cmd_q[19:4];
  assign c_tg  = cmd_q[20];
  assign c_tv  = cmd_q[36:21];
  assign c_zg  = cmd_q[37];
  assign c_zv  = cmd_q[45:38];
  assign c_num = cmd_q[53:46];
  assign c_png = cmd_q[54];
  assign c_rdy = cmd_q[55];
  assign c_acc = cmd_q[56];

  // move evaluation
  logic [3:0] mv_st;
  logic signed [15:0] np, nt;
  logic [7:0] nz;
  always_comb begin
    logic signed [15:0] sp, st, plo, phi, tlo, thi, zsum, zhi;
    logic done;
    plo = 16'(plo_q);
    phi = 16'(phi_q);
    tlo = 16'(tlo_q);
    thi = 16'(thi_q);
    zhi = 16'(signed'({1'b0, zhi_q}));
    np = pan_q;
    nt = tilt_q;
    nz = zoom_q;
    mv_st = ST_OK;
    done = 1'b0;
    sp = pan_q + c_pv;
    st = tilt_q + c_tv;
    zsum = 16'(signed'(8'(zoom_q + c_zv)));
    if (!c_rdy) begin
      mv_st = ST_BUSY;
      done = 1'b1;
    end
    if (!done && c_pg) begin
      if (!feat_q[0]) begin
        mv_st = ST_AXIS;
        done = 1'b1;
      end else if (c_req == REQ_REL) begin
        np = clamp16(sp, plo, phi);
      end else if (c_pv > phi || c_pv < plo) begin
        mv_st = ST_CONSTRAINT;
        done = 1'b1;
      end else begin
        np = c_pv;
      end
    end
    if (!done && c_tg) begin
      if (!feat_q[1]) begin
        mv_st = ST_AXIS;
        done = 1'b1;
      end else if (c_req == REQ_REL) begin
        nt = clamp16(st, tlo, thi);
      end else if (c_tv > thi || c_tv < tlo) begin
        mv_st = ST_CONSTRAINT;
        done = 1'b1;
      end else begin
        nt = c_tv;
      end
    end
    if (!done && c_zg) begin
      if (!feat_q[2]) begin
        mv_st = ST_AXIS;
        done = 1'b1;
      end else if (c_req == REQ_REL) begin
        nz = 8'(clamp16(clamp16(zsum, 16'sd1, zhi), 16'sd1, 16'sd32767));
      end else if (16'(c_zv) > zhi || c_zv < 8'sd1) begin
        mv_st = ST_CONSTRAINT;
        done = 1'b1;
      end else begin
        nz = c_zv;
      end
    end
    if (!done && !c_pg && !c_tg && !c_zg) begin
      mv_st = ST_INVALID;
      done = 1'b1;
    end
    if (!done && !c_acc) mv_st = ST_REJECTED;
  end

  logic [CntW-1:0] cap;
  assign cap = (int'(plim_q) > PRESET_SLOTS) ? CntW'(PRESET_SLOTS) : CntW'(plim_q);
  logic [8:0] cand;
  assign cand = {1'b0, next_q} + {4'd0, step_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (s_axis_tvalid && s_axis_tready) state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_OUT;
        if (feat_q[3] && (c_req == REQ_GOTO || c_req == REQ_REMOVE)) begin
          if (c_req == REQ_GOTO ? (c_rdy && cnt_q != '0)
                                : (c_num < {3'd0, plim_q} && cnt_q != '0))
            state_d = S_FIND_RD;
        end else if (feat_q[3] && c_req == REQ_SAVE && cnt_q < cap && c_acc) begin
          state_d = S_ALLOC_RD;
        end
      end
      S_FIND_RD:   state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (hit) begin
          if (!c_acc) state_d = S_OUT;
          else state_d = (c_req == REQ_GOTO) ? S_LOAD : S_SHIFT_RD;
        end else if (ptr_q + 1'b1 >= cnt_q) state_d = S_OUT;
        else state_d = S_FIND_RD;
      end
      S_LOAD_RD:   state_d = S_LOAD;
      S_LOAD:      state_d = S_OUT;
      S_SHIFT_RD:  state_d = (ptr_q + 1'b1 >= cnt_q) ? S_OUT : S_SHIFT_WR;
      S_SHIFT_WR:  state_d = S_SHIFT_RD;
      S_ALLOC_RD:  state_d = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (cand > 9'd255 || (ptr_q >= cnt_q)) state_d = S_OUT;
        else if (mem_rdata.id == cand[7:0]) begin
          state_d = ({1'b0, step_q} + 6'd1 < {1'b0, plim_q}) ? S_ALLOC_RD : S_OUT;
        end else state_d = S_ALLOC_RD;
      end
      S_OUT:       if (!out_v_q || m_axis_tready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pan_d = pan_q;
    tilt_d = tilt_q;
    zoom_d = zoom_q;
    cnt_d = cnt_q;
    next_d = next_q;
    cmd_d = cmd_q;
    ptr_d = ptr_q;
    hit = 1'b0;
    key_d = key_q;
    step_d = step_q;
    st_d = st_q;
    used_d = used_q;
    out_v_d = out_v_q && !m_axis_tready;
    out_d = out_q;
    mem_we = 1'b0;
    mem_waddr = ptr_q[IdxW-1:0];
    mem_raddr = ptr_q[IdxW-1:0];
    mem_wdata = mem_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) cmd_d = s_axis_tdata;
        ptr_d = '0;
      end
      S_DECIDE: begin
        used_d = '0;
        st_d = ST_OK;
        key_d = c_num;
        if (c_req == REQ_SET || c_req == REQ_REL) begin
          if (feat_q[2:0] == 3'd0) st_d = ST_UNSUPPORTED;
          else begin
            st_d = mv_st;
            if (mv_st == ST_OK) begin
              pan_d = np;
              tilt_d = nt;
              zoom_d = nz;
            end
          end
        end else if (c_req == REQ_GOTO || c_req == REQ_SAVE || c_req == REQ_REMOVE) begin
          if (!feat_q[3]) st_d = ST_UNSUPPORTED;
          else if (c_req == REQ_GOTO) begin
            st_d = !c_rdy ? ST_BUSY : ST_CONSTRAINT;
          end else if (c_req == REQ_REMOVE) begin
            st_d = (c_num < {3'd0, plim_q}) ? ST_NOTFOUND : ST_CONSTRAINT;
          end else if (cnt_q >= cap) st_d = ST_FULL;
          else if (!c_acc) st_d = ST_REJECTED;
          else begin
            mem_we = 1'b1;
            mem_waddr = cnt_q[IdxW-1:0];
            mem_wdata = '{id: c_png ? c_num : next_q, pan: pan_q, tilt: tilt_q,
                          zoom: zoom_q};
            used_d = c_png ? c_num : next_q;
            cnt_d = cnt_q + 1'b1;
            step_d = 5'd1;
          end
        end else st_d = ST_UNSUPPORTED;
      end
      S_FIND_CHK: begin
        hit = (mem_rdata.id == key_q);
        if (hit) begin
          if (!c_acc) st_d = ST_REJECTED;
          else begin
            st_d = ST_OK;
            if (c_req == REQ_GOTO) begin
              pan_d = mem_rdata.pan;
              tilt_d = mem_rdata.tilt;
              zoom_d = mem_rdata.zoom;
            end
          end
        end else ptr_d = ptr_q + 1'b1;
      end
      S_SHIFT_RD: begin
        mem_raddr = IdxW'(ptr_q + 1'b1);
        if (ptr_q + 1'b1 >= cnt_q) cnt_d = cnt_q - 1'b1;
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wdata = mem_rdata;
        ptr_d = ptr_q + 1'b1;
      end
      S_ALLOC_CHK: begin
        if (cand > 9'd255 || ptr_q >= cnt_q) begin
          next_d = cand[7:0];
        end else if (mem_rdata.id == cand[7:0]) begin
          ptr_d = '0;
          step_d = step_q + 1'b1;
        end else ptr_d = ptr_q + 1'b1;
      end
      S_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          out_d = OutWidth'({used_q, zoom_q[6:0], tilt_q[8:0], pan_q[8:0], st_q});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pan_q   <= '0;
      tilt_q  <= '0;
      zoom_q  <= 8'd1;
      cnt_q   <= '0;
      next_q  <= 8'd1;
      out_v_q <= 1'b0;
      ptr_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pan_q   <= pan_d;
      tilt_q  <= tilt_d;
      zoom_q  <= zoom_d;
      cnt_q   <= cnt_d;
      next_q  <= next_d;
      out_v_q <= out_v_d;
      ptr_q   <= ptr_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    st_q   <= st_d;
    used_q <= used_d;
    out_q  <= out_d;
  end

  `PTZ_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(PRESET_SLOTS),
    "preset count above slot count")
  `PTZ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !m_axis_tready,
    out_v_q && $stable(m_axis_tdata), "result dropped while stalled")
  `PTZ_ASSERT_NEXT(a_one_out, clk_i, rst_ni,
    state_q == S_OUT && (!out_v_q || m_axis_tready),
    out_v_q && state_q == S_IDLE, "result not presented after command")
  `PTZ_ASSERT_ALWAYS(a_zoom_min, clk_i, rst_ni, zoom_q != 8'd0 || cnt_q != '0,
    "zoom position zero")

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the PTZ position and preset engine.
`timescale 1ns / 100ps
`default_nettype none
module testbench
  import ptz_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]         req;
    bit                 pg;
    logic signed [15:0] pv;
    bit                 tg;
    logic signed [15:0] tv;
    bit                 zg;
    logic signed [7:0]  zv;
    logic [7:0]         num;
    bit                 ng;
    bit                 rdy;
    bit                 acc;
  } ptz_cmd_t;

  typedef struct {
    status_e            st;
    logic signed [8:0]  pan;
    logic signed [8:0]  tilt;
    logic [6:0]         zoom;
    logic [7:0]         used;
  } ptz_pos_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire logic           s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  wire logic           m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire logic [OutWidth-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [8:0]          cfg_data_i = '0;

  ptz_position_preset_engine dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]        feat;
  logic signed [8:0] pan_lo, pan_hi, tilt_lo, tilt_hi;
  logic [6:0]        zoom_hi;
  logic [4:0]        plim;
  int pos_pan, pos_tilt, pos_zoom;
  int tab_id[SLOTS], tab_pan[SLOTS], tab_tilt[SLOTS], tab_zoom[SLOTS];
  int tab_n, next_id;

  ptz_pos_t pos_q[$];
  int snd_idle, rcv_idle;
  int mismatches = 0;
  int stall_cnt = 0;

  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = 16'(v);
    return t;
  endfunction

  function automatic int wrap8(int v);
    logic signed [7:0] t;
    t = 8'(v);
    return t;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int find_preset(int id);
    for (int i = 0; i < tab_n; i++)
      if (tab_id[i] == id) return i;
    return -1;
  endfunction

  function automatic status_e apply_move(ptz_cmd_t c, bit rel);
    int np, nt, nz;
    np = pos_pan;
    nt = pos_tilt;
    nz = pos_zoom;
    if (!c.rdy) return ST_BUSY;
    if (c.pg) begin
      if (!feat[0]) return ST_AXIS;
      if (rel) begin
        np = clampi(wrap16(pos_pan + int'(c.pv)), int'(pan_lo), int'(pan_hi));
      end else begin
        if (int'(c.pv) > int'(pan_hi) || int'(c.pv) < int'(pan_lo)) return ST_CONSTRAINT;
        np = c.pv;
      end
    end
    if (c.tg) begin
      if (!feat[1]) return ST_AXIS;
      if (rel) begin
        nt = clampi(wrap16(pos_tilt + int'(c.tv)), int'(tilt_lo), int'(tilt_hi));
      end else begin
        if (int'(c.tv) > int'(tilt_hi) || int'(c.tv) < int'(tilt_lo)) return ST_CONSTRAINT;
        nt = c.tv;
      end
    end
    if (c.zg) begin
      if (!feat[2]) return ST_AXIS;
      if (rel) begin
        nz = clampi(wrap8(pos_zoom + int'(c.zv)), 1, int'(zoom_hi));
        if (nz < 1) nz = 1;
      end else begin
        if (int'(c.zv) > int'(zoom_hi) || int'(c.zv) < 1) return ST_CONSTRAINT;
        nz = c.zv;
      end
    end
    if (!c.pg && !c.tg && !c.zg) return ST_INVALID;
    if (!c.acc) return ST_REJECTED;
    pos_pan = np;
    pos_tilt = nt;
    pos_zoom = nz;
    return ST_OK;
  endfunction

  function automatic void advance_next_id();
    int step, cand;
    step = 1;
    do begin
      cand = next_id + step;
      if (cand > 255 || find_preset(cand) < 0) begin
        next_id = cand & 255;
        return;
      end
      step++;
    end while (step < int'(plim));
  endfunction

  function automatic ptz_pos_t predict_position(ptz_cmd_t c);
    ptz_pos_t r;
    int idx, cap, id;
    r.st = ST_OK;
    r.used = '0;
    if (c.req == REQ_SET || c.req == REQ_REL) begin
      if (feat[2:0] == 3'b000) r.st = ST_UNSUPPORTED;
      else r.st = apply_move(c, c.req == REQ_REL);
    end else if (c.req == REQ_GOTO || c.req == REQ_SAVE || c.req == REQ_REMOVE) begin
      if (!feat[3]) begin
        r.st = ST_UNSUPPORTED;
      end else if (c.req == REQ_GOTO) begin
        idx = find_preset(c.num);
        if (!c.rdy) r.st = ST_BUSY;
        else if (idx < 0) r.st = ST_CONSTRAINT;
        else if (!c.acc) r.st = ST_REJECTED;
        else begin
          pos_pan = tab_pan[idx];
          pos_tilt = tab_tilt[idx];
          pos_zoom = tab_zoom[idx];
        end
      end else if (c.req == REQ_SAVE) begin
        cap = (int'(plim) > SLOTS) ? SLOTS : int'(plim);
        id = c.ng ? int'(c.num) : next_id;
        if (tab_n >= cap) r.st = ST_FULL;
        else if (!c.acc) r.st = ST_REJECTED;
        else begin
          tab_id[tab_n] = id;
          tab_pan[tab_n] = pos_pan;
          tab_tilt[tab_n] = pos_tilt;
          tab_zoom[tab_n] = pos_zoom;
          tab_n++;
          advance_next_id();
          r.used = 8'(id);
        end
      end else begin
        idx = find_preset(c.num);
        if (int'(c.num) >= int'(plim)) r.st = ST_CONSTRAINT;
        else if (idx < 0) r.st = ST_NOTFOUND;
        else if (!c.acc) r.st = ST_REJECTED;
        else begin
          for (int i = idx; i + 1 < tab_n; i++) begin
            tab_id[i] = tab_id[i+1];
            tab_pan[i] = tab_pan[i+1];
            tab_tilt[i] = tab_tilt[i+1];
            tab_zoom[i] = tab_zoom[i+1];
          end
          tab_n--;
        end
      end
    end else begin
      r.st = ST_UNSUPPORTED;
    end
    r.pan = 9'(pos_pan);
    r.tilt = 9'(pos_tilt);
    r.zoom = 7'(pos_zoom);
    return r;
  endfunction

  function automatic ptz_cmd_t mk(logic [2:0] req, bit pg, int pv, bit tg, int tv,
                                   bit zg, int zv, int num, bit ng, bit rdy, bit acc);
    ptz_cmd_t c;
    c.req = req; c.pg = pg; c.pv = 16'(pv); c.tg = tg; c.tv = 16'(tv); c.zg = zg;
    c.zv = 8'(zv); c.num = 8'(num); c.ng = ng; c.rdy = rdy; c.acc = acc;
    return c;
  endfunction

  task automatic send_request(ptz_cmd_t c);
    logic [63:0] bits;
    bits = {7'd0, c.acc, c.rdy, c.ng, c.num, c.zv, c.zg, c.tv, c.tg, c.pv, c.pg, c.req};
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bits[InWidth-1:0];
    do @(posedge clk_i); while (!s_axis_tready);
    pos_q = {pos_q, predict_position(c)};
  endtask

  task automatic drain();
    while (pos_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(cfg_e idx, int val);
    drain();
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 9'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FEATURE:    feat = 4'(val);
      CFG_PAN_LO:     pan_lo = 9'(val);
      CFG_PAN_HI:     pan_hi = 9'(val);
      CFG_TILT_LO:    tilt_lo = 9'(val);
      CFG_TILT_HI:    tilt_hi = 9'(val);
      CFG_ZOOM_HI:    zoom_hi = 7'(val);
      CFG_PRESET_LIM: plim = 5'(val);
      default: ;
    endcase
  endtask

  // check results in arrival order
  always @(posedge clk_i) begin
    ptz_pos_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pos_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = pos_q.pop_front();
        if (m_axis_tdata[3:0] !== e.st || m_axis_tdata[12:4] !== e.pan ||
            m_axis_tdata[21:13] !== e.tilt || m_axis_tdata[28:22] !== e.zoom ||
            m_axis_tdata[36:29] !== e.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pan=%0d tilt=%0d zoom=%0d used=%0d got %h",
                     e.st, e.pan, e.tilt, e.zoom, e.used, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(mk(REQ_SET, 1, -180, 1, 180, 1, 100, 0, 0, 1, 1));
    send_request(mk(REQ_SET, 1, 181, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SET, 0, 0, 1, -181, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SET, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SET, 1, 10, 0, 0, 0, 0, 0, 0, 0, 1));
    send_request(mk(REQ_SET, 1, 10, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(mk(REQ_REL, 1, 32767, 1, -32768, 1, 127, 0, 0, 1, 1));
    send_request(mk(REQ_REL, 1, -32768, 1, 32767, 1, -128, 0, 0, 1, 1));
    send_request(mk(REQ_GOTO, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 2, 1, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 255, 1, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 2, 1, 1, 0));
    send_request(mk(REQ_SET, 1, 5, 1, 6, 1, 7, 0, 0, 1, 1));
    send_request(mk(REQ_GOTO, 0, 0, 0, 0, 0, 0, 2, 0, 0, 1));
    send_request(mk(REQ_GOTO, 0, 0, 0, 0, 0, 0, 2, 0, 1, 0));
    send_request(mk(REQ_GOTO, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1));
    send_request(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 16, 0, 1, 1));
    send_request(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 9, 0, 1, 1));
    send_request(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
    send_request(mk(REQ_BAD5, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_request(mk(REQ_BAD6, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_BAD7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_config_corners();
    write_reg(CFG_PRESET_LIM, 2);
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    write_reg(CFG_PAN_LO, 50);
    write_reg(CFG_PAN_HI, -50);
    send_request(mk(REQ_SET, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_REL, 1, 3, 0, 0, 0, 0, 0, 0, 1, 1));
    write_reg(CFG_FEATURE, 4'b1000);
    send_request(mk(REQ_SET, 1, 0, 1, 0, 1, 1, 0, 0, 1, 1));
    write_reg(CFG_FEATURE, 4'b0110);
    send_request(mk(REQ_SET, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    write_reg(CFG_FEATURE, 4'b0101);
    send_request(mk(REQ_REL, 0, 0, 1, 4, 0, 0, 0, 0, 1, 1));
    write_reg(CFG_PRESET_LIM, 0);
    send_request(mk(REQ_SAVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  function automatic ptz_cmd_t random_cmd();
    ptz_cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 4) c.req = 3'($urandom_range(7, 5));
    else c.req = 3'($urandom_range(4, 0));
    c.pg = $urandom_range(3) != 0;
    c.tg = $urandom_range(3) != 0;
    c.zg = $urandom_range(3) != 0;
    c.pv = 16'(($urandom_range(9) < 7) ? $urandom_range(420) - 210 : $urandom);
    c.tv = 16'(($urandom_range(9) < 7) ? $urandom_range(420) - 210 : $urandom);
    c.zv = 8'(($urandom_range(9) < 7) ? $urandom_range(115) - 8 : $urandom);
    c.num = 8'(($urandom_range(9) < 8) ? $urandom_range(20) : $urandom);
    c.ng = $urandom_range(1) != 0;
    c.rdy = $urandom_range(9) != 0;
    c.acc = $urandom_range(9) != 0;
    return c;
  endfunction

  task automatic random_config();
    int r;
    r = $urandom_range(3);
    write_reg(CFG_FEATURE, ($urandom_range(4) == 0) ? $urandom_range(15) : 15);
    write_reg(CFG_PAN_LO, (r == 0) ? -180 : $urandom_range(60) - 120);
    write_reg(CFG_PAN_HI, (r == 0) ? 180 : (r == 1) ? -130 : $urandom_range(180));
    write_reg(CFG_TILT_LO, (r == 0) ? -180 : $urandom_range(100) - 180);
    write_reg(CFG_TILT_HI, (r == 2) ? 180 : $urandom_range(360) - 180);
    write_reg(CFG_ZOOM_HI, (r == 0) ? 100 : (r == 1) ? 2 : $urandom_range(100, 2));
    write_reg(CFG_PRESET_LIM, (r == 0) ? 16 : $urandom_range(16));
  endtask

  task automatic test_random(int s_idle, int r_idle);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    for (int k = 0; k < 3; k++) begin
      random_config();
      for (int i = 0; i < 110; i++) begin
        if (i == 55) drain();
        send_request(random_cmd());
      end
    end
  endtask

  initial begin
    feat = 4'hf;
    pan_lo = -180; pan_hi = 180; tilt_lo = -180; tilt_hi = 180;
    zoom_hi = 100; plim = 16;
    pos_pan = 0; pos_tilt = 0; pos_zoom = 1;
    tab_n = 0; next_id = 1;
    snd_idle = 0; rcv_idle = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_corners();
    test_random(34, 53);
    test_random(53, 34);
    test_random(0, 0);
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pos_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
